FILE: src/keyed_count_table_with_sum_assert.svh
// Assertion macros for the keyed count table checks.
// Both expect clk and rst in scope at the point of use.
`ifndef KEYED_COUNT_TABLE_WITH_SUM_ASSERT_SVH
`define KEYED_COUNT_TABLE_WITH_SUM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed count table check failed");

// Consequent must hold in the cycle after the antecedent.
`define KCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed count table check failed");

`endif

FILE: src/kct_pkg.sv
`default_nettype none

package kct_pkg;

  localparam int KEY_IN_BITS     = 40;
  localparam int PRICE_BITS      = 24;
  localparam int SUM_BITS        = 40;
  localparam int ITEM_COUNT_BITS = 16;
  localparam int ENTRIES_BITS    = 8;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_INC       = 3'd1,
    ST_DEC       = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // Commands from the sequencer to the price accumulator.
  typedef struct packed {
    logic load;
    logic en;
    logic sub;
  } acc_op_t;

endpackage

`default_nettype wire

FILE: src/keyed_count_table_with_sum.sv
`default_nettype none

// Keyed count table with running price sum. Pulse start while busy is low to
// add (mode 0) or remove (mode 1) one of item_key, priced at price_cents. The
// block searches its insertion-ordered table one entry per cycle through the
// single read port of the entry RAM, then decides and writes in its act state.
// When a remove drops an entry to zero, the later entries move down one place
// per cycle through the same RAM ports. The result is shown for exactly one
// cycle with done high, the cycle after the last table update. The receiver
// cannot stall it, so sample it when done is seen. The scan stops at a hit;
// a miss scans every entry in use, and an empty table skips the scan. A new
// item may start in the done cycle. No clearing pass follows reset.
module keyed_count_table_with_sum import kct_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BITS    = 40,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [KEY_IN_BITS-1:0]     item_key,
  input  logic [PRICE_BITS-1:0]      price_cents,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [ITEM_COUNT_BITS-1:0] item_count,
  output logic [ENTRIES_BITS-1:0]    entries_used,
  output logic signed [SUM_BITS-1:0] running_total
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + COUNT_BITS;

  logic [IW-1:0]         rd_addr;
  logic [EW-1:0]         rd_data;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  acc_op_t               acc_op;
  status_t               status_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [UW-1:0]         used;
  logic [SUM_BITS-1:0]   sum;

  kct_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .item_key   (item_key),
    .busy       (busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .acc_op     (acc_op),
    .done       (done),
    .status     (status_q),
    .item_count (count_q),
    .used       (used)
  );

  kct_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kct_acc u_acc (
    .clk   (clk),
    .rst   (rst),
    .op    (acc_op),
    .price (price_cents),
    .sum   (sum)
  );

  assign status        = status_q;
  assign item_count    = ITEM_COUNT_BITS'(count_q);
  assign entries_used  = ENTRIES_BITS'(used);
  assign running_total = $signed(sum);

endmodule

`default_nettype wire

FILE: src/kct_ram.sv
`default_nettype none

module kct_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/kct_acc.sv
`default_nettype none

module kct_acc import kct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  acc_op_t               op,
  input  logic [PRICE_BITS-1:0] price,
  output logic [SUM_BITS-1:0]   sum
);

  logic [PRICE_BITS-1:0] price_r;
  logic [SUM_BITS-1:0]   addend;

  assign addend = SUM_BITS'(price_r);

  always_ff @(posedge clk) begin
    if (op.load) begin
      price_r <= price;
    end
  end

  // Sum wraps modulo 2^SUM_BITS.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (op.en) begin
      sum <= op.sub ? sum - addend : sum + addend;
    end
  end

endmodule

`default_nettype wire

FILE: src/kct_seq.sv
`default_nettype none

module kct_seq import kct_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BITS    = 40,
  parameter int COUNT_BITS  = 16,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int UW = $clog2(TABLE_DEPTH + 1),
  localparam int EW = KEY_BITS + COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   mode,
  input  logic [KEY_IN_BITS-1:0] item_key,
  output logic                   busy,
  output logic [IW-1:0]          rd_addr,
  input  logic [EW-1:0]          rd_data,
  output logic                   wr_en,
  output logic [IW-1:0]          wr_addr,
  output logic [EW-1:0]          wr_data,
  output acc_op_t                acc_op,
  output logic                   done,
  output status_t                status,
  output logic [COUNT_BITS-1:0]  item_count,
  output logic [UW-1:0]          used
);

  localparam int XW = UW + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_ACT   = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [IW-1:0]         idx, idx_next;
  logic [UW-1:0]         used_next;
  logic                  op_rm, op_rm_next;
  logic [KEY_BITS-1:0]   op_key, op_key_next;
  logic                  hit, hit_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic                  done_next;
  status_t               status_next;
  logic [COUNT_BITS-1:0] item_count_next;

  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [XW-1:0]         idx_x1, idx_x2, used_x;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;

  assign rd_key  = rd_data[EW-1:COUNT_BITS];
  assign rd_cnt  = rd_data[COUNT_BITS-1:0];
  assign idx_x1  = XW'(idx) + XW'(1);
  assign idx_x2  = XW'(idx) + XW'(2);
  assign used_x  = XW'(used);
  assign cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
  assign cnt_dec = cnt - 1'b1;
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    used_next       = used;
    op_rm_next      = op_rm;
    op_key_next     = op_key;
    hit_next        = hit;
    cnt_next        = cnt;
    done_next       = 1'b0;
    status_next     = status;
    item_count_next = item_count;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = {op_key, cnt};
    acc_op          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_rm_next  = mode;
          op_key_next = KEY_BITS'(item_key);
          hit_next    = 1'b0;
          idx_next    = '0;
          acc_op.load = 1'b1;
          state_next  = (used == '0) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        // rd_data holds entry idx; fetch idx+1 in case of a miss
        rd_addr = IW'(idx_x1);
        if (rd_key == op_key) begin
          hit_next   = 1'b1;
          cnt_next   = rd_cnt;
          state_next = S_ACT;
        end else if (idx_x1 == used_x) begin
          state_next = S_ACT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_ACT: begin
        rd_addr    = IW'(idx_x1);
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (!op_rm) begin
          if (hit) begin
            wr_en           = 1'b1;
            wr_data         = {op_key, cnt_inc};
            acc_op.en       = 1'b1;
            status_next     = ST_INC;
            item_count_next = cnt_inc;
          end else if (used != UW'(TABLE_DEPTH)) begin
            wr_en           = 1'b1;
            wr_addr         = IW'(used);
            wr_data         = {op_key, COUNT_BITS'(1)};
            used_next       = used + 1'b1;
            acc_op.en       = 1'b1;
            status_next     = ST_NEW;
            item_count_next = COUNT_BITS'(1);
          end else begin
            status_next     = ST_FULL;
            item_count_next = '0;
          end
        end else if (hit) begin
          acc_op.en  = 1'b1;
          acc_op.sub = 1'b1;
          if (cnt_dec != '0) begin
            wr_en           = 1'b1;
            wr_data         = {op_key, cnt_dec};
            status_next     = ST_DEC;
            item_count_next = cnt_dec;
          end else begin
            status_next     = ST_REMOVED;
            item_count_next = '0;
            if (idx_x1 < used_x) begin
              // close the gap before reporting
              state_next = S_SHIFT;
              done_next  = 1'b0;
            end else begin
              used_next = used - 1'b1;
            end
          end
        end else begin
          status_next     = ST_NOT_FOUND;
          item_count_next = '0;
        end
      end
      S_SHIFT: begin
        // rd_data holds entry idx+1; move it down one place
        rd_addr = IW'(idx_x2);
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (idx_x2 == used_x) begin
          used_next  = used - 1'b1;
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    op_rm      <= op_rm_next;
    op_key     <= op_key_next;
    hit        <= hit_next;
    cnt        <= cnt_next;
    status     <= status_next;
    item_count <= item_count_next;
  end

endmodule

`default_nettype wire

FILE: src/kct_checker.sv
`default_nettype none

`include "keyed_count_table_with_sum_assert.svh"

module kct_checker import kct_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [2:0]                 status,
  input logic [ITEM_COUNT_BITS-1:0] item_count
);

  logic no_count;

  // Results that leave the key absent report a zero count.
  assign no_count = done && (status == ST_NOT_FOUND || status == ST_FULL ||
                             status == ST_REMOVED);

  `KCT_ASSERT_NEXT(a_done_single, done, !done)
  `KCT_ASSERT_SAME(a_done_idle, done, !busy)
  `KCT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `KCT_ASSERT_SAME(a_new_one, done && status == ST_NEW, item_count == 16'd1)
  `KCT_ASSERT_SAME(a_absent_zero, no_count, item_count == '0)

endmodule

bind keyed_count_table_with_sum kct_checker u_kct_checker (.*);

`default_nettype wire
